// ===== sv/cpt_pkg.sv =====
// Shared constants, types and tables for the colour patch test pattern unit.
// Used by cpt_geometry, cpt_pixel and color_patch_test_pattern_unit; no dependencies.
`timescale 1ns / 1ps

package cpt_pkg;

	localparam int DIM_W  = 9;   // raster coordinates and frame sizes
	localparam int GEO_W  = 10;  // patch geometry and patch edges
	localparam int EDGE_W = 12;  // signed glyph edges

	localparam int MAX_WIDTH  = 320;
	localparam int MAX_HEIGHT = 320;
	localparam int MIN_DIM    = 64;
	localparam int SCALE_MAX  = 8;

	localparam int GRID_COLS  = 6;
	localparam int GRID_ROWS  = 4;
	localparam int DOT_COLS   = 5;
	localparam int DOT_ROWS   = 7;

	// x / 6 == (x * 171) >> 10 for every x below 512
	localparam int DIV6_MUL   = 171;
	localparam int DIV6_SHIFT = 10;

	localparam int BUSY_CYCLES = 8;
	localparam int BUSY_W      = 4;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 40;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GAP_SIZE     = 2'd2;
	localparam logic [1:0] REG_DOT_SCALE    = 2'd3;

	localparam logic [8:0] RST_FRAME_WIDTH  = 9'd240;
	localparam logic [8:0] RST_FRAME_HEIGHT = 9'd320;
	localparam logic [2:0] RST_GAP_SIZE     = 3'd2;
	localparam logic [3:0] RST_DOT_SCALE    = 4'd5;

	localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
	localparam logic [15:0] COLOR_BLACK = 16'h0000;

	localparam logic [DOT_COLS-1:0] GLYPH_B [0:DOT_ROWS-1] =
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
	localparam logic [DOT_COLS-1:0] GLYPH_W [0:DOT_ROWS-1] =
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};

	// RGB888 reference colours, row by row
	localparam logic [23:0] PATCH_RGB [0:GRID_ROWS-1][0:GRID_COLS-1] = '{
		'{24'hF3F3F2, 24'hC8C8C8, 24'hA0A0A0, 24'h7A7A79, 24'h555555, 24'h343434},
		'{24'h383D96, 24'h469449, 24'hAF363C, 24'hE7C71F, 24'hBB5695, 24'h0088AA},
		'{24'hD67E2C, 24'h505BA6, 24'hC15A63, 24'h5E3C6C, 24'h9DBC40, 24'hE0A32E},
		'{24'h735244, 24'hC29682, 24'h627A9D, 24'h576C43, 24'h8580B1, 24'h67BDAA}
	};

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [2:0]       gap_size;
		logic [3:0]       dot_scale;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} dims_t;

	typedef struct packed {
		logic [GEO_W-1:0] pw;
		logic [GEO_W-1:0] ph;
		logic [GEO_W-1:0] ox;
		logic [GEO_W-1:0] oy;
	} geom_t;

	typedef struct packed {
		geom_t                    geom;
		logic [GEO_W-1:0]         sx;
		logic [GEO_W-1:0]         sy;
		logic signed [EDGE_W-1:0] lxb;
		logic signed [EDGE_W-1:0] ly;
		logic [3:0]               s;
	} pre_t;

	// Patch spans [lo, hi) and glyph dot edges; glyph edges may be negative
	typedef struct packed {
		logic [GRID_COLS-1:0][GEO_W-1:0]   px_lo;
		logic [GRID_COLS-1:0][GEO_W-1:0]   px_hi;
		logic [GRID_ROWS-1:0][GEO_W-1:0]   py_lo;
		logic [GRID_ROWS-1:0][GEO_W-1:0]   py_hi;
		logic [DOT_COLS:0][EDGE_W-1:0]     gxb;
		logic [DOT_COLS:0][EDGE_W-1:0]     gxw;
		logic [DOT_ROWS:0][EDGE_W-1:0]     gy;
	} edges_t;

	function automatic logic [15:0] to565(logic [23:0] rgb);
		return {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

endpackage

// ===== sv/cpt_geometry.sv =====
// Patch and glyph geometry: derives patch sizes, origin and all edge positions
// from the register file, holds the set in use for the current frame. Uses cpt_pkg.
`timescale 1ns / 1ps

module cpt_geometry (
	input  logic            clk,
	input  logic            arst_n,
	input  cpt_pkg::cfg_t   cfg,
	input  logic            cfg_wr,
	input  logic            latch,
	output logic            busy,
	output cpt_pkg::dims_t  dims,
	output cpt_pkg::edges_t edges
);

	localparam int GW = cpt_pkg::GEO_W;
	localparam int EW = cpt_pkg::EDGE_W;
	localparam int PW = cpt_pkg::GEO_W + 8;

	logic [cpt_pkg::BUSY_W-1:0] busy_q;
	logic [cpt_pkg::DIM_W-1:0]  ew_q, eh_q;
	logic [2:0]                 g_q;
	logic [3:0]                 s_q;
	logic [GW-1:0]              w_raw, h_raw, w_eff, h_eff;
	logic [3:0]                 s_eff;

	logic [GW-1:0]              wg_s1, hg_s1;
	logic [GW-1:0]              pw_s2, ph_s2;
	logic [PW-1:0]              prod;
	cpt_pkg::geom_t             cand_geom_s3, cand_geom_d;
	cpt_pkg::pre_t              cand_pre_s4;
	cpt_pkg::edges_t            cand_edges_s5;
	cpt_pkg::geom_t             act_geom_q;
	cpt_pkg::pre_t              act_pre_s1;
	cpt_pkg::edges_t            act_edges_s2;
	cpt_pkg::edges_t            edges_q;

	function automatic cpt_pkg::pre_t edge_pre(cpt_pkg::geom_t gm, logic [2:0] g,
		logic [3:0] s);
		cpt_pkg::pre_t p;
		logic signed [EW-1:0] dx, dy;
		p.geom = gm;
		p.s    = s;
		p.sx   = gm.pw + GW'(g);
		p.sy   = gm.ph + GW'(g);
		// (patch - glyph) / 2, truncated toward zero
		dx = $signed(EW'(gm.pw)) - $signed(EW'(s) * EW'(cpt_pkg::DOT_COLS));
		dx = dx + $signed(EW'(dx[EW-1]));
		dy = $signed(EW'(gm.ph)) - $signed(EW'(s) * EW'(cpt_pkg::DOT_ROWS));
		dy = dy + $signed(EW'(dy[EW-1]));
		p.lxb = $signed(EW'(gm.ox)) + (dx >>> 1);
		p.ly  = $signed(EW'(gm.oy)) + (dy >>> 1);
		return p;
	endfunction

	function automatic cpt_pkg::edges_t edge_final(cpt_pkg::pre_t p);
		cpt_pkg::edges_t e;
		logic signed [EW-1:0] lxw;
		for (int q = 0; q < cpt_pkg::GRID_COLS; q++) begin
			e.px_lo[q] = p.geom.ox + GW'(q) * p.sx;
			e.px_hi[q] = e.px_lo[q] + p.geom.pw;
		end
		for (int q = 0; q < cpt_pkg::GRID_ROWS; q++) begin
			e.py_lo[q] = p.geom.oy + GW'(q) * p.sy;
			e.py_hi[q] = e.py_lo[q] + p.geom.ph;
		end
		lxw = p.lxb + $signed(EW'(p.sx) * EW'(cpt_pkg::GRID_COLS - 1));
		for (int k = 0; k <= cpt_pkg::DOT_COLS; k++) begin
			e.gxb[k] = p.lxb + $signed(EW'(k) * EW'(p.s));
			e.gxw[k] = lxw + $signed(EW'(k) * EW'(p.s));
		end
		for (int k = 0; k <= cpt_pkg::DOT_ROWS; k++) begin
			e.gy[k] = p.ly + $signed(EW'(k) * EW'(p.s));
		end
		return e;
	endfunction

	// saturate the raw registers into their working ranges
	always_comb begin
		w_raw = GW'(cfg.frame_width);
		h_raw = GW'(cfg.frame_height);
		if (w_raw < GW'(cpt_pkg::MIN_DIM)) begin
			w_eff = GW'(cpt_pkg::MIN_DIM);
		end else if (w_raw > GW'(cpt_pkg::MAX_WIDTH)) begin
			w_eff = GW'(cpt_pkg::MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < GW'(cpt_pkg::MIN_DIM)) begin
			h_eff = GW'(cpt_pkg::MIN_DIM);
		end else if (h_raw > GW'(cpt_pkg::MAX_HEIGHT)) begin
			h_eff = GW'(cpt_pkg::MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
		if (cfg.dot_scale == 4'd0) begin
			s_eff = 4'd1;
		end else if (cfg.dot_scale > 4'(cpt_pkg::SCALE_MAX)) begin
			s_eff = 4'(cpt_pkg::SCALE_MAX);
		end else begin
			s_eff = cfg.dot_scale;
		end
	end

	always_comb begin
		prod = PW'(wg_s1) * PW'(cpt_pkg::DIV6_MUL);
		cand_geom_d.pw = pw_s2;
		cand_geom_d.ph = ph_s2;
		cand_geom_d.ox = (GW'(ew_q) - (pw_s2 * GW'(cpt_pkg::GRID_COLS)
			+ GW'(g_q) * GW'(cpt_pkg::GRID_COLS - 1))) >> 1;
		cand_geom_d.oy = (GW'(eh_q) - (ph_s2 * GW'(cpt_pkg::GRID_ROWS)
			+ GW'(g_q) * GW'(cpt_pkg::GRID_ROWS - 1))) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= cpt_pkg::BUSY_W'(cpt_pkg::BUSY_CYCLES);
		end else if (cfg_wr) begin
			busy_q <= cpt_pkg::BUSY_W'(cpt_pkg::BUSY_CYCLES);
		end else if (busy_q != '0) begin
			busy_q <= busy_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ew_q <= w_eff[cpt_pkg::DIM_W-1:0];
		eh_q <= h_eff[cpt_pkg::DIM_W-1:0];
		g_q  <= cfg.gap_size;
		s_q  <= s_eff;

		// next-frame geometry, refreshed continuously from the registers
		wg_s1 <= GW'(ew_q) - GW'(g_q) * GW'(cpt_pkg::GRID_COLS);
		hg_s1 <= GW'(eh_q) - GW'(g_q) * GW'(cpt_pkg::GRID_ROWS);
		pw_s2 <= GW'(prod >> cpt_pkg::DIV6_SHIFT);
		ph_s2 <= hg_s1 >> 2;
		cand_geom_s3  <= cand_geom_d;
		cand_pre_s4   <= edge_pre(cand_geom_s3, g_q, s_q);
		cand_edges_s5 <= edge_final(cand_pre_s4);

		// frame geometry stays, but gap and scale are live: rebuild edges after a write
		act_pre_s1   <= edge_pre(act_geom_q, g_q, s_q);
		act_edges_s2 <= edge_final(act_pre_s1);

		if (latch) begin
			act_geom_q <= cand_geom_s3;
			edges_q    <= cand_edges_s5;
		end else if (busy_q != '0) begin
			edges_q    <= act_edges_s2;
		end
	end

	assign busy   = (busy_q != '0);
	assign dims.w = ew_q;
	assign dims.h = eh_q;
	assign edges  = edges_q;

endmodule

// ===== sv/cpt_pixel.sv =====
// Pixel colour lookup: glyph dots, patch colour or black for one raster position.
// Pure compare-and-select logic on the edge set from cpt_geometry. Uses cpt_pkg.
`timescale 1ns / 1ps

module cpt_pixel (
	input  logic [cpt_pkg::DIM_W-1:0] x,
	input  logic [cpt_pkg::DIM_W-1:0] y,
	input  cpt_pkg::edges_t           edges,
	output logic [15:0]               color
);

	localparam int EW = cpt_pkg::EDGE_W;
	localparam int GW = cpt_pkg::GEO_W;

	logic signed [EW-1:0] xs, ys;
	logic                 in_w, in_b, in_rows;
	logic [2:0]           cw, cb, r;
	logic                 dot_w, dot_b;
	logic                 col_hit, row_hit;
	logic [2:0]           q;
	logic [1:0]           p;

	always_comb begin
		xs = $signed(EW'(x));
		ys = $signed(EW'(y));

		in_rows = (ys >= $signed(edges.gy[0]))
			&& (ys < $signed(edges.gy[cpt_pkg::DOT_ROWS]));
		in_w = in_rows && (xs >= $signed(edges.gxw[0]))
			&& (xs < $signed(edges.gxw[cpt_pkg::DOT_COLS]));
		in_b = in_rows && (xs >= $signed(edges.gxb[0]))
			&& (xs < $signed(edges.gxb[cpt_pkg::DOT_COLS]));

		// dot column and row by thermometer count over the dot edges
		cw = '0;
		cb = '0;
		for (int k = 1; k < cpt_pkg::DOT_COLS; k++) begin
			if (xs >= $signed(edges.gxw[k])) cw = cw + 3'd1;
			if (xs >= $signed(edges.gxb[k])) cb = cb + 3'd1;
		end
		r = '0;
		for (int k = 1; k < cpt_pkg::DOT_ROWS; k++) begin
			if (ys >= $signed(edges.gy[k])) r = r + 3'd1;
		end
		dot_w = cpt_pkg::GLYPH_W[r][3'(cpt_pkg::DOT_COLS - 1) - cw];
		dot_b = cpt_pkg::GLYPH_B[r][3'(cpt_pkg::DOT_COLS - 1) - cb];

		col_hit = 1'b0;
		q       = '0;
		for (int k = 0; k < cpt_pkg::GRID_COLS; k++) begin
			if (GW'(x) >= edges.px_lo[k] && GW'(x) < edges.px_hi[k]) begin
				col_hit = 1'b1;
				q       = 3'(k);
			end
		end
		row_hit = 1'b0;
		p       = '0;
		for (int k = 0; k < cpt_pkg::GRID_ROWS; k++) begin
			if (GW'(y) >= edges.py_lo[k] && GW'(y) < edges.py_hi[k]) begin
				row_hit = 1'b1;
				p       = 2'(k);
			end
		end

		// white label wins over black label, both win over the patch
		if (in_w && dot_w) begin
			color = cpt_pkg::COLOR_WHITE;
		end else if (in_b && dot_b) begin
			color = cpt_pkg::COLOR_BLACK;
		end else if (col_hit && row_hit) begin
			color = cpt_pkg::to565(cpt_pkg::PATCH_RGB[p][q]);
		end else begin
			color = cpt_pkg::COLOR_BLACK;
		end
	end

endmodule

// ===== sv/color_patch_test_pattern_unit.sv =====
// Colour patch test pattern: one RGB565 pixel word out per word in, raster order.
// Registers s1, s2 lead to the output; 1 pixel per clock while m_tready is high, busy low.
// The output register and the pixel stage let a new word in while a result waits.
// After reset and after every register write the input side holds s_tready low
// while the geometry pipeline in cpt_geometry settles.
// Reset clears the raster to pixel (0,0) and loads the register defaults.
`timescale 1ns / 1ps

module color_patch_test_pattern_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cpt_pkg::TDATA_IN_W-1:0]    s_tdata,  // [0] restart, rest zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] pixel_color, [24:16] pixel_column, [33:25] pixel_line, rest zero
	output logic [cpt_pkg::TDATA_OUT_W-1:0]   m_tdata,
	output logic                              m_tlast,  // frame_last
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cpt_pkg::APB_AW-1:0]        paddr,
	input  logic [cpt_pkg::APB_DW-1:0]        pwdata,
	output logic [cpt_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);

	localparam int DW = cpt_pkg::DIM_W;

	cpt_pkg::cfg_t   cfg_q;
	cpt_pkg::dims_t  dims;
	cpt_pkg::edges_t edges;
	logic            cfg_wr, busy, in_acc, frame_start;
	logic            adv_s1, adv_s2;

	logic [DW-1:0]   col_q, line_q;
	logic [DW-1:0]   c0, l0, c1, l1, x, y, col_n, line_n;
	logic [DW:0]     nx, ny;
	logic            last;

	logic            v_s1, last_s1;
	logic [DW-1:0]   x_s1, y_s1;
	logic            v_s2, last_s2;
	logic [DW-1:0]   x_s2, y_s2;
	logic [15:0]     color_s2, color;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= cpt_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height <= cpt_pkg::RST_FRAME_HEIGHT;
			cfg_q.gap_size     <= cpt_pkg::RST_GAP_SIZE;
			cfg_q.dot_scale    <= cpt_pkg::RST_DOT_SCALE;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cpt_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DW-1:0];
				cpt_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DW-1:0];
				cpt_pkg::REG_GAP_SIZE:     cfg_q.gap_size     <= pwdata[2:0];
				cpt_pkg::REG_DOT_SCALE:    cfg_q.dot_scale    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cpt_pkg::REG_FRAME_WIDTH:  prdata = cpt_pkg::APB_DW'(cfg_q.frame_width);
			cpt_pkg::REG_FRAME_HEIGHT: prdata = cpt_pkg::APB_DW'(cfg_q.frame_height);
			cpt_pkg::REG_GAP_SIZE:     prdata = cpt_pkg::APB_DW'(cfg_q.gap_size);
			cpt_pkg::REG_DOT_SCALE:    prdata = cpt_pkg::APB_DW'(cfg_q.dot_scale);
			default:                   prdata = '0;
		endcase
	end

	cpt_geometry u_geometry (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cfg_wr (cfg_wr),
		.latch  (in_acc && frame_start),
		.busy   (busy),
		.dims   (dims),
		.edges  (edges)
	);

	// handshake: the whole pipe moves when the output word is taken or empty
	assign adv_s2   = !v_s2 || m_tready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1 && !busy;
	assign in_acc   = s_tvalid && s_tready;

	// raster position for the incoming word, including wrap after a size change
	always_comb begin
		c0 = s_tdata[0] ? '0 : col_q;
		l0 = s_tdata[0] ? '0 : line_q;
		if (c0 >= dims.w) begin
			c1 = '0;
			l1 = l0 + 1'b1;
		end else begin
			c1 = c0;
			l1 = l0;
		end
		if (l1 >= dims.h) begin
			x = '0;
			y = '0;
		end else begin
			x = c1;
			y = l1;
		end
		frame_start = (x == '0) && (y == '0);
		last = (x == dims.w - 1'b1) && (y == dims.h - 1'b1);

		nx = {1'b0, x} + 1'b1;
		ny = {1'b0, y} + 1'b1;
		if (nx >= {1'b0, dims.w}) begin
			col_n  = '0;
			line_n = (ny >= {1'b0, dims.h}) ? '0 : ny[DW-1:0];
		end else begin
			col_n  = nx[DW-1:0];
			line_n = y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (in_acc) begin
				col_q  <= col_n;
				line_q <= line_n;
			end
			if (adv_s1) v_s1 <= in_acc;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// a frame-start word only enters s1 as the previous word leaves it,
	// so the word in s1 always sees the geometry of its own frame
	cpt_pixel u_pixel (
		.x     (x_s1),
		.y     (y_s1),
		.edges (edges),
		.color (color)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1    <= x;
			y_s1    <= y;
			last_s1 <= last;
		end
		if (adv_s2 && v_s1) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			last_s2  <= last_s1;
			color_s2 <= color;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {6'b0, y_s2, x_s2, color_s2};

endmodule
